@@ hw/rtl/ssa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the structure score accumulator.
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam int COORD_W = 24;
	localparam int DIST_W  = 50;
	localparam int SCALE_W = 32;
	localparam int SUM_W   = 33;
	localparam int CNT_W   = 17;
	localparam int TERM_W  = 17;
	localparam int QBITS   = 16;
	localparam int NUM_GDT = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	localparam logic [1:0] REG_D0     = 2'd0;
	localparam logic [1:0] REG_D8     = 2'd1;
	localparam logic [1:0] REG_CUTOFF = 2'd2;

	localparam logic [SCALE_W-1:0] D0_RESET = 32'd25000000;
	localparam logic [SCALE_W-1:0] D8_RESET = 32'd100000000;
	localparam logic [SCALE_W-1:0] MAXSUB_D2 = 32'd12250000;
	localparam logic [DIST_W-1:0] WITHIN10_D2 = 50'd100000000;

	localparam logic [DIST_W-1:0] GDT_LIMIT [NUM_GDT] = '{
		50'd250000, 50'd1000000, 50'd4000000, 50'd16000000, 50'd64000000
	};

	// Classified request passed from front to back
	typedef struct packed {
		logic [DIST_W-1:0] dist2;
		logic [NUM_GDT-1:0] gdt_hit;
		logic main_en;
		logic within10;
		logic maxsub_en;
		logic last;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC
	} back_state_t;

endpackage

@@ hw/rtl/structure_score_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// structure_score_accumulator
// GDT, MaxSub and TM-score accumulation over streamed coordinate pairs.
//
// channel | signals                          | request
// input   | push, full, model_*, ref_*, last | one atom pair
// result  | pop, empty, *_sum, gdt_*         | totals of one set
// config  | cfg_valid, cfg_ready, cfg_*      | one register write
//
// Front: two pipeline stages (abs diff, squares and sum), one pair per cycle
// unless the queue is full. Back: one pair at a time, through the shared
// bit-serial divider (17 steps per quotient), again when the MaxSub term is needed.
// A pair marked last waits while the previous result is still unread.
// Reset clears running counters and sums, not the held result; registers take reset values.
// ----------------------------------------------------------------------------
module structure_score_accumulator (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [ssa_pkg::COORD_W-1:0] model_x,
	input  logic signed [ssa_pkg::COORD_W-1:0] model_y,
	input  logic signed [ssa_pkg::COORD_W-1:0] model_z,
	input  logic signed [ssa_pkg::COORD_W-1:0] ref_x,
	input  logic signed [ssa_pkg::COORD_W-1:0] ref_y,
	input  logic signed [ssa_pkg::COORD_W-1:0] ref_z,
	input  logic last_pair,
	output logic empty,
	input  logic pop,
	output logic [ssa_pkg::SUM_W-1:0] main_score_sum,
	output logic [ssa_pkg::SUM_W-1:0] tm_all_sum,
	output logic [ssa_pkg::SUM_W-1:0] tm_within10_sum,
	output logic [ssa_pkg::SUM_W-1:0] maxsub_sum,
	output logic [ssa_pkg::CNT_W-1:0] gdt_half,
	output logic [ssa_pkg::CNT_W-1:0] gdt_one,
	output logic [ssa_pkg::CNT_W-1:0] gdt_two,
	output logic [ssa_pkg::CNT_W-1:0] gdt_four,
	output logic [ssa_pkg::CNT_W-1:0] gdt_eight,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [ssa_pkg::SCALE_W-1:0] cfg_data
);
	logic [ssa_pkg::SCALE_W-1:0] d0_q, d8_q;
	logic cutoff_q;
	logic in_ready, f_valid, f_ready, q_valid, q_ready, res_valid;
	ssa_pkg::item_t f_item, q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0_q <= ssa_pkg::D0_RESET;
			d8_q <= ssa_pkg::D8_RESET;
			cutoff_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ssa_pkg::REG_D0: d0_q <= cfg_data;
				ssa_pkg::REG_D8: d8_q <= cfg_data;
				ssa_pkg::REG_CUTOFF: cutoff_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ssa_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push), .in_ready(in_ready),
		.model_x(model_x), .model_y(model_y), .model_z(model_z),
		.ref_x(ref_x), .ref_y(ref_y), .ref_z(ref_z), .last_pair(last_pair),
		.d8_squared(d8_q), .cutoff_mode(cutoff_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	ssa_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_item(f_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	ssa_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_ready(q_ready),
		.in_item(q_item), .d0_squared(d0_q), .res_valid(res_valid), .res_ready(pop),
		.main_score_sum(main_score_sum), .tm_all_sum(tm_all_sum),
		.tm_within10_sum(tm_within10_sum), .maxsub_sum(maxsub_sum),
		.gdt_half(gdt_half), .gdt_one(gdt_one), .gdt_two(gdt_two),
		.gdt_four(gdt_four), .gdt_eight(gdt_eight)
	);

	assign full = !in_ready;
	assign empty = !res_valid;

`ifndef SYNTHESIS
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(main_score_sum) && $stable(gdt_eight)))
		else $error("result changed while waiting");
	a_gdt_nested: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (gdt_half <= gdt_one && gdt_one <= gdt_two &&
		gdt_two <= gdt_four && gdt_four <= gdt_eight))
		else $error("gdt counts not nested");
	a_tm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (tm_within10_sum <= tm_all_sum))
		else $error("tm within10 exceeds tm all");
`endif

endmodule

@@ hw/rtl/ssa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_front
// Accepts coordinate pairs, forms squared distance, classifies thresholds.
// ----------------------------------------------------------------------------
module ssa_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [ssa_pkg::COORD_W-1:0] model_x,
	input  logic signed [ssa_pkg::COORD_W-1:0] model_y,
	input  logic signed [ssa_pkg::COORD_W-1:0] model_z,
	input  logic signed [ssa_pkg::COORD_W-1:0] ref_x,
	input  logic signed [ssa_pkg::COORD_W-1:0] ref_y,
	input  logic signed [ssa_pkg::COORD_W-1:0] ref_z,
	input  logic last_pair,
	input  logic [ssa_pkg::SCALE_W-1:0] d8_squared,
	input  logic cutoff_mode,
	output logic out_valid,
	input  logic out_ready,
	output ssa_pkg::item_t out_item
);
	logic v_s1, v_s2;
	logic [ssa_pkg::COORD_W:0] ax_s1, ay_s1, az_s1;
	logic last_s1;
	logic [ssa_pkg::DIST_W-1:0] dist_s2;
	logic last_s2;
	logic adv_s1, adv_s2;
	logic [2*ssa_pkg::COORD_W+1:0] sqx, sqy, sqz;

	function automatic logic [ssa_pkg::COORD_W:0] absdiff(
		input logic signed [ssa_pkg::COORD_W-1:0] a,
		input logic signed [ssa_pkg::COORD_W-1:0] b);
		logic signed [ssa_pkg::COORD_W:0] d;
		d = {a[ssa_pkg::COORD_W-1], a} - {b[ssa_pkg::COORD_W-1], b};
		return d[ssa_pkg::COORD_W] ? -d : d;
	endfunction

	assign adv_s2 = !v_s2 || out_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign sqx = ax_s1 * ax_s1;
	assign sqy = ay_s1 * ay_s1;
	assign sqz = az_s1 * az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			ax_s1 <= absdiff(model_x, ref_x);
			ay_s1 <= absdiff(model_y, ref_y);
			az_s1 <= absdiff(model_z, ref_z);
			last_s1 <= last_pair;
		end
		if (adv_s2 && v_s1) begin
			dist_s2 <= ssa_pkg::DIST_W'(sqx) + ssa_pkg::DIST_W'(sqy)
				+ ssa_pkg::DIST_W'(sqz);
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		out_item.dist2 = dist_s2;
		for (int i = 0; i < ssa_pkg::NUM_GDT; i++)
			out_item.gdt_hit[i] = dist_s2 <= ssa_pkg::GDT_LIMIT[i];
		out_item.main_en = !(cutoff_mode &&
			dist_s2 > ssa_pkg::DIST_W'(d8_squared));
		out_item.within10 = dist_s2 < ssa_pkg::WITHIN10_D2;
		out_item.maxsub_en = dist_s2 < ssa_pkg::DIST_W'(ssa_pkg::MAXSUB_D2);
		out_item.last = last_s2;
	end
	assign out_valid = v_s2;

endmodule

@@ hw/rtl/ssa_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module ssa_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  ssa_pkg::item_t wr_item,
	output logic rd_valid,
	input  logic rd_ready,
	output ssa_pkg::item_t rd_item
);
	ssa_pkg::item_t mem_q [ssa_pkg::FIFO_DEPTH];
	logic [ssa_pkg::FIFO_AW-1:0] wp_q, rp_q;
	logic [ssa_pkg::FIFO_AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (ssa_pkg::FIFO_AW+1)'(ssa_pkg::FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

endmodule

@@ hw/rtl/ssa_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_divider
// Restoring divider, one quotient bit per cycle: floor(2^16*s/(s+d)).
// ----------------------------------------------------------------------------
module ssa_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ssa_pkg::SCALE_W-1:0] scale,
	input  logic [ssa_pkg::DIST_W-1:0] dist2,
	output logic busy,
	output logic done,
	output logic [ssa_pkg::TERM_W-1:0] quot
);
	localparam int DEN_W = ssa_pkg::DIST_W + 1;
	localparam int CW = 5;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] rem_q;
	logic [ssa_pkg::TERM_W-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DEN_W:0] trial;
	logic [DEN_W-1:0] den_n;

	// quotient <= 2^16, so rem stays < den; 17 steps with first step on s
	assign den_n = DEN_W'(scale) + DEN_W'(dist2);
	assign trial = {rem_q[DEN_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(ssa_pkg::QBITS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den_n;
			if (den_n == '0) begin
				rem_q <= '0;
				quot_q <= ssa_pkg::TERM_W'(1) << ssa_pkg::QBITS;
			end else if ((DEN_W+1)'(scale) >= {1'b0, den_n}) begin
				rem_q <= (DEN_W+1)'(scale) - {1'b0, den_n};
				quot_q <= ssa_pkg::TERM_W'(1);
			end else begin
				rem_q <= (DEN_W+1)'(scale);
				quot_q <= '0;
			end
		end else if (busy_q && cnt_q != '0) begin
			if (den_q == '0) begin
				quot_q <= quot_q;
			end else if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quot_q <= {quot_q[ssa_pkg::TERM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[ssa_pkg::TERM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ hw/rtl/ssa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_back
// Computes TM and MaxSub terms and updates the accumulators.
// ----------------------------------------------------------------------------
module ssa_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ssa_pkg::item_t in_item,
	input  logic [ssa_pkg::SCALE_W-1:0] d0_squared,
	output logic res_valid,
	input  logic res_ready,
	output logic [ssa_pkg::SUM_W-1:0] main_score_sum,
	output logic [ssa_pkg::SUM_W-1:0] tm_all_sum,
	output logic [ssa_pkg::SUM_W-1:0] tm_within10_sum,
	output logic [ssa_pkg::SUM_W-1:0] maxsub_sum,
	output logic [ssa_pkg::CNT_W-1:0] gdt_half,
	output logic [ssa_pkg::CNT_W-1:0] gdt_one,
	output logic [ssa_pkg::CNT_W-1:0] gdt_two,
	output logic [ssa_pkg::CNT_W-1:0] gdt_four,
	output logic [ssa_pkg::CNT_W-1:0] gdt_eight
);
	ssa_pkg::back_state_t state_q, state_n;
	ssa_pkg::item_t item_q;
	logic phase_q, phase_n;
	logic [ssa_pkg::TERM_W-1:0] tm_q;
	logic [ssa_pkg::TERM_W-1:0] ms_q;
	logic [ssa_pkg::SUM_W-1:0] sum_q [4];
	logic [ssa_pkg::CNT_W-1:0] cnt_q [ssa_pkg::NUM_GDT];
	logic [ssa_pkg::SUM_W-1:0] osum_q [4];
	logic [ssa_pkg::CNT_W-1:0] ocnt_q [ssa_pkg::NUM_GDT];
	logic res_valid_q;
	logic div_start, div_busy, div_done;
	logic [ssa_pkg::SCALE_W-1:0] div_scale;
	logic [ssa_pkg::TERM_W-1:0] div_quot;
	logic take, acc;
	logic [3:0] add_en;
	logic [ssa_pkg::TERM_W-1:0] add_v [4];

	function automatic logic [ssa_pkg::SUM_W-1:0] sat_add(
		input logic [ssa_pkg::SUM_W-1:0] s, input logic [ssa_pkg::TERM_W-1:0] v);
		logic [ssa_pkg::SUM_W:0] t;
		t = {1'b0, s} + (ssa_pkg::SUM_W+1)'(v);
		return t[ssa_pkg::SUM_W] ? '1 : t[ssa_pkg::SUM_W-1:0];
	endfunction

	assign div_scale = phase_q ? ssa_pkg::MAXSUB_D2 : d0_squared;

	ssa_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .scale(div_scale),
		.dist2(item_q.dist2), .busy(div_busy), .done(div_done), .quot(div_quot)
	);

	always_comb begin
		state_n = state_q;
		phase_n = phase_q;
		div_start = 1'b0;
		take = 1'b0;
		acc = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			ssa_pkg::ST_IDLE: begin
				in_ready = !(in_valid && in_item.last && res_valid_q);
				if (in_valid && in_ready) begin
					take = 1'b1;
					state_n = ssa_pkg::ST_DIV;
					phase_n = 1'b0;
				end
			end
			ssa_pkg::ST_DIV: begin
				if (!div_busy && !div_done) begin
					div_start = 1'b1;
				end else if (div_done) begin
					if (!phase_q && item_q.maxsub_en) begin
						phase_n = 1'b1;
					end else begin
						state_n = ssa_pkg::ST_ACC;
					end
				end
			end
			ssa_pkg::ST_ACC: begin
				acc = 1'b1;
				state_n = ssa_pkg::ST_IDLE;
			end
			default: state_n = ssa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		add_en = {item_q.maxsub_en, item_q.within10, 1'b1, item_q.main_en};
		add_v[0] = tm_q;
		add_v[1] = tm_q;
		add_v[2] = tm_q;
		add_v[3] = ms_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssa_pkg::ST_IDLE;
			phase_q <= 1'b0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) sum_q[k] <= '0;
			for (int i = 0; i < ssa_pkg::NUM_GDT; i++) cnt_q[i] <= '0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (acc) begin
				for (int k = 0; k < 4; k++)
					sum_q[k] <= item_q.last ? '0 :
						(add_en[k] ? sat_add(sum_q[k], add_v[k]) : sum_q[k]);
				for (int i = 0; i < ssa_pkg::NUM_GDT; i++)
					cnt_q[i] <= item_q.last ? '0 :
						((item_q.gdt_hit[i] && cnt_q[i] != '1) ?
						cnt_q[i] + 1'b1 : cnt_q[i]);
				if (item_q.last) res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_q <= in_item;
		if (div_done && !phase_q) tm_q <= div_quot;
		if (div_done && phase_q) ms_q <= div_quot;
		if (acc && item_q.last) begin
			for (int k = 0; k < 4; k++)
				osum_q[k] <= add_en[k] ? sat_add(sum_q[k], add_v[k]) : sum_q[k];
			for (int i = 0; i < ssa_pkg::NUM_GDT; i++)
				ocnt_q[i] <= (item_q.gdt_hit[i] && cnt_q[i] != '1) ?
					cnt_q[i] + 1'b1 : cnt_q[i];
		end
	end

	assign res_valid = res_valid_q;
	assign main_score_sum = osum_q[0];
	assign tm_all_sum = osum_q[1];
	assign tm_within10_sum = osum_q[2];
	assign maxsub_sum = osum_q[3];
	assign gdt_half = ocnt_q[0];
	assign gdt_one = ocnt_q[1];
	assign gdt_two = ocnt_q[2];
	assign gdt_four = ocnt_q[3];
	assign gdt_eight = ocnt_q[4];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for structure_score_accumulator: streams coordinate pairs
// through the push/full port, predicts the set totals in a local scoring model
// and checks every popped result field by field, with random idling on both
// sides, a long result stall and register changes between sets.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam longint unsigned Q_ONE = 65536;
	localparam longint unsigned SUM_MAX = 64'h1_FFFF_FFFF;
	localparam longint unsigned CNT_MAX = 64'h1_FFFF;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [ssa_pkg::COORD_W-1:0] mx, my, mz, rx, ry, rz;
		logic last;
	} pair_t;

	typedef struct {
		logic [ssa_pkg::SUM_W-1:0] sums [4];
		logic [ssa_pkg::CNT_W-1:0] cnts [ssa_pkg::NUM_GDT];
	} totals_t;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic signed [ssa_pkg::COORD_W-1:0] model_x = 0, model_y = 0, model_z = 0;
	logic signed [ssa_pkg::COORD_W-1:0] ref_x = 0, ref_y = 0, ref_z = 0;
	logic last_pair = 0;
	logic empty;
	logic pop = 0;
	logic [ssa_pkg::SUM_W-1:0] main_score_sum, tm_all_sum, tm_within10_sum, maxsub_sum;
	logic [ssa_pkg::CNT_W-1:0] gdt_half, gdt_one, gdt_two, gdt_four, gdt_eight;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [ssa_pkg::SCALE_W-1:0] cfg_data = 0;

	structure_score_accumulator u_top (.*);

	pair_t pending_pairs [$];
	totals_t totals_q [$];
	pair_t cur_pair;

	longint unsigned d0_sq, d8_sq, cut_mode;
	longint unsigned gdt_acc [ssa_pkg::NUM_GDT];
	longint unsigned sum_acc [4];
	longint unsigned gdt_lim [ssa_pkg::NUM_GDT] =
		'{250000, 1000000, 4000000, 16000000, 64000000};

	int send_idle = 0, recv_idle = 0;
	int hold_reqs = 0, hold_seen = 0, hold_cnt = 0;
	int errors = 0;
	int cycles = 0;

	initial forever #5 clk = ~clk;

	function automatic longint unsigned q16_ratio(longint unsigned scale, longint unsigned d2);
		longint unsigned den;
		den = scale + d2;
		if (den == 0)
			return Q_ONE;
		return (Q_ONE * scale) / den;
	endfunction

	function automatic longint unsigned sq_delta(logic signed [ssa_pkg::COORD_W-1:0] a,
			logic signed [ssa_pkg::COORD_W-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return longint'(d * d);
	endfunction

	function automatic void add_sat(int k, longint unsigned v);
		sum_acc[k] = (sum_acc[k] + v > SUM_MAX) ? SUM_MAX : sum_acc[k] + v;
	endfunction

	function automatic void score_pair(pair_t p);
		longint unsigned d2, tm;
		totals_t t;
		d2 = sq_delta(p.mx, p.rx) + sq_delta(p.my, p.ry) + sq_delta(p.mz, p.rz);
		for (int i = 0; i < ssa_pkg::NUM_GDT; i++)
			if (d2 <= gdt_lim[i] && gdt_acc[i] < CNT_MAX)
				gdt_acc[i]++;
		tm = q16_ratio(d0_sq, d2);
		if (!(cut_mode == 1 && d2 > d8_sq))
			add_sat(0, tm);
		add_sat(1, tm);
		if (d2 < 64'd100000000)
			add_sat(2, tm);
		if (d2 < 64'd12250000)
			add_sat(3, q16_ratio(64'd12250000, d2));
		if (p.last) begin
			for (int i = 0; i < 4; i++) begin
				t.sums[i] = sum_acc[i][ssa_pkg::SUM_W-1:0];
				sum_acc[i] = 0;
			end
			for (int i = 0; i < ssa_pkg::NUM_GDT; i++) begin
				t.cnts[i] = gdt_acc[i][ssa_pkg::CNT_W-1:0];
				gdt_acc[i] = 0;
			end
			totals_q.push_back(t);
		end
	endfunction

	// pair driver
	always @(posedge clk) begin
		if (push && !full)
			score_pair(cur_pair);
		if (!push || !full) begin
			if (arst_n && pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
				cur_pair = pending_pairs.pop_front();
				model_x <= cur_pair.mx;
				model_y <= cur_pair.my;
				model_z <= cur_pair.mz;
				ref_x <= cur_pair.rx;
				ref_y <= cur_pair.ry;
				ref_z <= cur_pair.rz;
				last_pair <= cur_pair.last;
				push <= 1;
			end else begin
				push <= 0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		totals_t exp_t, got;
		got.sums = '{main_score_sum, tm_all_sum, tm_within10_sum, maxsub_sum};
		got.cnts = '{gdt_half, gdt_one, gdt_two, gdt_four, gdt_eight};
		if (pop && !empty) begin
			if (totals_q.size() == 0) begin
				$display("%0t: unexpected result, main_score_sum %0d", $time, main_score_sum);
				errors++;
			end else begin
				exp_t = totals_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got.sums[i] !== exp_t.sums[i]) begin
						$display("%0t: sum %0d expected %0d actual %0d", $time, i,
							exp_t.sums[i], got.sums[i]);
						errors++;
					end
				for (int i = 0; i < ssa_pkg::NUM_GDT; i++)
					if (got.cnts[i] !== exp_t.cnts[i]) begin
						$display("%0t: gdt count %0d expected %0d actual %0d", $time, i,
							exp_t.cnts[i], got.cnts[i]);
						errors++;
					end
			end
		end
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_cnt = 800;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			pop <= 0;
		end else begin
			pop <= arst_n && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic add_pair(int mx, int my, int mz, int rx, int ry, int rz, bit last);
		pair_t p;
		p.mx = ssa_pkg::COORD_W'(mx); p.my = ssa_pkg::COORD_W'(my);
		p.mz = ssa_pkg::COORD_W'(mz);
		p.rx = ssa_pkg::COORD_W'(rx); p.ry = ssa_pkg::COORD_W'(ry);
		p.rz = ssa_pkg::COORD_W'(rz);
		p.last = last;
		pending_pairs.push_back(p);
	endtask

	task automatic add_random_pair(bit last);
		pair_t p;
		p.rx = ssa_pkg::COORD_W'($urandom);
		p.ry = ssa_pkg::COORD_W'($urandom);
		p.rz = ssa_pkg::COORD_W'($urandom);
		if ($urandom_range(9) < 7) begin
			p.mx = ssa_pkg::COORD_W'(p.rx + $signed($urandom_range(20000)) - 10000);
			p.my = ssa_pkg::COORD_W'(p.ry + $signed($urandom_range(20000)) - 10000);
			p.mz = ssa_pkg::COORD_W'(p.rz + $signed($urandom_range(20000)) - 10000);
		end else begin
			p.mx = ssa_pkg::COORD_W'($urandom);
			p.my = ssa_pkg::COORD_W'($urandom);
			p.mz = ssa_pkg::COORD_W'($urandom);
		end
		p.last = last;
		pending_pairs.push_back(p);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [ssa_pkg::SCALE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		case (idx)
			ssa_pkg::REG_D0:     d0_sq = 64'(val);
			ssa_pkg::REG_D8:     d8_sq = 64'(val);
			ssa_pkg::REG_CUTOFF: cut_mode = 64'(val[0]);
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_pairs.size() > 0 || push || totals_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		write_reg(ssa_pkg::REG_D0, $urandom_range(50000000, 250000));
		write_reg(ssa_pkg::REG_D8, $urandom);
		write_reg(ssa_pkg::REG_CUTOFF, $urandom);
		for (int i = 0; i < n; i++)
			add_random_pair(i == n - 1 || $urandom_range(11) == 0);
		wait_idle();
	endtask

	initial begin
		d0_sq = 64'(ssa_pkg::D0_RESET);
		d8_sq = 64'(ssa_pkg::D8_RESET);
		cut_mode = 0;
		for (int i = 0; i < 4; i++) sum_acc[i] = 0;
		for (int i = 0; i < ssa_pkg::NUM_GDT; i++) gdt_acc[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// thresholds and extremes at reset configuration
		add_pair(0, 0, 0, 0, 0, 0, 0);
		add_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0);
		add_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0);
		add_pair(500, 0, 0, 0, 0, 0, 0);
		add_pair(501, 0, 0, 0, 0, 0, 0);
		add_pair(0, 1000, 0, 0, 0, 0, 0);
		add_pair(0, 0, 2000, 0, 0, 0, 0);
		add_pair(-4000, 0, 0, 0, 0, 0, 0);
		add_pair(0, 0, 0, 8000, 0, 0, 0);
		add_pair(8001, 0, 0, 0, 0, 0, 0);
		add_pair(3499, 0, 0, 0, 0, 0, 0);
		add_pair(3500, 0, 0, 0, 0, 0, 0);
		add_pair(9999, 0, 0, 0, 0, 0, 0);
		add_pair(10000, 0, 0, 0, 0, 0, 1);
		add_pair(300, -7, 12, 0, 0, 0, 1);
		wait_idle();

		// zero scale, tightest cutoff, ignored index
		write_reg(ssa_pkg::REG_D0, 0);
		write_reg(ssa_pkg::REG_D8, 0);
		write_reg(ssa_pkg::REG_CUTOFF, 1);
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		add_pair(5, 5, 5, 5, 5, 5, 0);
		add_pair(1, 0, 0, 0, 0, 0, 1);
		wait_idle();

		write_reg(ssa_pkg::REG_D0, 32'hFFFF_FFFF);
		write_reg(ssa_pkg::REG_D8, 32'hFFFF_FFFF);
		add_pair(8388607, 0, 0, -8388608, 0, 0, 0);
		add_pair(1234, 0, 0, 0, 0, 0, 1);
		wait_idle();

		write_reg(ssa_pkg::REG_D0, 250000);
		write_reg(ssa_pkg::REG_D8, 64000000);
		add_pair(8000, 0, 0, 0, 0, 0, 0);
		add_pair(8001, 0, 0, 0, 0, 0, 1);
		wait_idle();
		write_reg(ssa_pkg::REG_CUTOFF, 32'hFFFF_FFFE);

		// long result stall with a stream of one-pair sets behind it
		send_idle = 19;
		recv_idle = 68;
		hold_reqs++;
		for (int i = 0; i < 30; i++)
			add_random_pair(1);
		wait_idle();

		random_phase(240);
		send_idle = 68;
		recv_idle = 19;
		random_phase(250);
		send_idle = 0;
		recv_idle = 0;
		random_phase(250);

		wait_idle();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_front.sv
hw/rtl/ssa_fifo.sv
hw/rtl/ssa_divider.sv
hw/rtl/ssa_back.sv
hw/rtl/structure_score_accumulator.sv
tb/tb_top.sv
